// ===== src/cwa_pkg.sv =====
package cwa_pkg;

    // Fixed field widths of the ports
    localparam int IN_W        = 16;
    localparam int AVAIL_W     = 20;
    localparam int PRIO_W      = 4;
    localparam int CFG_IDX_W   = 2;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_SLOTS  = 16;
    localparam int DEF_SHARE_BITS = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AVAIL     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRIO_EN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRIO_SLOT = 2'd2;

    typedef struct packed {
        logic [IN_W-1:0] slot_min;
        logic [IN_W-1:0] slot_ideal;
        logic [IN_W-1:0] slot_weight;
        logic            final_slot;
    } slot_in_t;

    typedef struct packed {
        logic [AVAIL_W-1:0] slot_share;
        logic               final_share;
    } share_out_t;

endpackage

// ===== src/cwa_ram.sv =====
module cwa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one entry with registered data
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/cwa_div.sv =====
module cwa_div #(
    parameter int DVD_W = 36,
    parameter int DVS_W = 22
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient,
    output logic [DVS_W-1:0] remainder
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [DVS_W:0]    part_reg, part_next;
    logic [DVS_W:0]    trial;
    logic              fits;

    // Shift in one dividend bit and try one subtract per cycle
    assign trial = {part_reg[DVS_W-1:0], quo_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        part_next = part_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = STEP_W'(DVD_W);
            quo_next  = dividend;
            part_next = '0;
        end else if (busy_reg) begin
            part_next = fits ? (trial - {1'b0, divisor}) : trial;
            quo_next  = {quo_reg[DVD_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg  <= quo_next;
        part_reg <= part_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = part_reg[DVS_W-1:0];

endmodule

// ===== src/capped_weighted_apportioner_core.sv =====
// Channel   Direction  Handshake              Payload
// s_        in         s_valid / s_ready      slot_in_t: min, ideal, weight, final flag
// m_        out        m_valid / m_ready      share_out_t: share, final flag
// cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// Slots load at one per cycle; the block stays ready until the final slot.
// A set of n slots is then summed and seeded, each capped round marks its members,
// each capped or weighted round runs every member through the shared divider,
// and leftover units are handed out one at a time, each after a scan for the best slot.
// Shares then leave in load order, each held until the receiver takes it.
// Reset is synchronous; no clearing pass is needed after it.
module capped_weighted_apportioner_core import cwa_pkg::*; #(
    parameter int MAX_SLOTS  = DEF_MAX_SLOTS,
    parameter int SHARE_BITS = DEF_SHARE_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  slot_in_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output share_out_t           m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [AVAIL_W-1:0]   cfg_data
);

    localparam int AW     = AVAIL_W;
    localparam int VAL_W  = (SHARE_BITS < IN_W) ? SHARE_BITS : IN_W;
    localparam int IDX_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int SUM_W  = VAL_W + CNT_W;
    localparam int PROD_W = AW + VAL_W;
    localparam int CMP_W  = (SUM_W > AW) ? SUM_W : AW;

    localparam logic [4:0] ST_LOAD      = 5'd0;
    localparam logic [4:0] ST_SUM_RD    = 5'd1;
    localparam logic [4:0] ST_SUM_USE   = 5'd2;
    localparam logic [4:0] ST_DECIDE    = 5'd3;
    localparam logic [4:0] ST_INIT_RD   = 5'd4;
    localparam logic [4:0] ST_INIT_USE  = 5'd5;
    localparam logic [4:0] ST_PRI_RD    = 5'd6;
    localparam logic [4:0] ST_PRI_USE   = 5'd7;
    localparam logic [4:0] ST_ROUND     = 5'd8;
    localparam logic [4:0] ST_ACT_RD    = 5'd9;
    localparam logic [4:0] ST_ACT_USE   = 5'd10;
    localparam logic [4:0] ST_ACT_END   = 5'd11;
    localparam logic [4:0] ST_DIV_RD    = 5'd12;
    localparam logic [4:0] ST_DIV_MUL   = 5'd13;
    localparam logic [4:0] ST_DIV_START = 5'd14;
    localparam logic [4:0] ST_DIV_WAIT  = 5'd15;
    localparam logic [4:0] ST_TIE_PREP  = 5'd16;
    localparam logic [4:0] ST_TIE_RD    = 5'd17;
    localparam logic [4:0] ST_TIE_USE   = 5'd18;
    localparam logic [4:0] ST_TIE_PICK  = 5'd19;
    localparam logic [4:0] ST_INC_RD    = 5'd20;
    localparam logic [4:0] ST_INC_USE   = 5'd21;
    localparam logic [4:0] ST_ROUND_END = 5'd22;
    localparam logic [4:0] ST_SPREAD    = 5'd23;
    localparam logic [4:0] ST_EM_RD     = 5'd24;
    localparam logic [4:0] ST_EM_LD     = 5'd25;
    localparam logic [4:0] ST_EM_WAIT   = 5'd26;

    localparam logic [1:0] MODE_MIN = 2'd0;
    localparam logic [1:0] MODE_FIT = 2'd1;
    localparam logic [1:0] MODE_CAP = 2'd2;

    // Control registers
    logic [4:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              m_valid_reg, m_valid_next;
    logic [AW-1:0]     avail_reg, avail_next;
    logic              prio_en_reg, prio_en_next;
    logic [PRIO_W-1:0] prio_slot_reg, prio_slot_next;

    // Working registers
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [1:0]           mode_reg, mode_next;
    logic                 spread_reg, spread_next;
    logic [SUM_W-1:0]     min_sum_reg, min_sum_next;
    logic [SUM_W-1:0]     ideal_sum_reg, ideal_sum_next;
    logic [SUM_W-1:0]     wsum_reg, wsum_next;
    logic [SUM_W-1:0]     csum_reg, csum_next;
    logic [AW-1:0]        rem_reg, rem_next;
    logic [AW-1:0]        used_reg, used_next;
    logic                 prio_ok_reg, prio_ok_next;
    logic [IDX_W-1:0]     prio_idx_reg, prio_idx_next;
    logic                 any_reg, any_next;
    logic                 found_reg, found_next;
    logic [SUM_W-1:0]     best_r_reg, best_r_next;
    logic [VAL_W-1:0]     best_w_reg, best_w_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [MAX_SLOTS-1:0] active_reg, active_next;
    logic [MAX_SLOTS-1:0] chosen_reg, chosen_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    share_out_t           m_data_reg, m_data_next;

    // Memory ports
    logic                 slot_we;
    logic [3*VAL_W-1:0]   slot_wd, slot_rd;
    logic                 share_we;
    logic [AW-1:0]        share_wd, share_rd;
    logic                 remst_we;
    logic [SUM_W-1:0]     remst_rd;

    // Divider ports
    logic                 div_start;
    logic                 div_done;
    logic [PROD_W-1:0]    div_quo;
    logic [SUM_W-1:0]     div_rem;
    logic [SUM_W-1:0]     divisor;

    // Decoded read data and helpers
    logic [VAL_W-1:0]     rd_min, rd_ideal, rd_weight, cap_val, weff, need;
    logic [AW-1:0]        room, quo_q, q_final, grant;
    logic                 last, is_prio, share_lt_ideal, member, cand, better;
    logic [CMP_W-1:0]     avail_c, min_c, ideal_c;

    assign rd_min    = slot_rd[3*VAL_W-1 -: VAL_W];
    assign rd_ideal  = slot_rd[2*VAL_W-1 -: VAL_W];
    assign rd_weight = slot_rd[VAL_W-1:0];

    assign last           = (32'(idx_reg) + 32'd1) == 32'(cnt_reg);
    assign is_prio        = prio_ok_reg && (idx_reg == prio_idx_reg);
    assign share_lt_ideal = share_rd < AW'(rd_ideal);
    assign cap_val        = rd_ideal - rd_min;
    assign need           = (rd_ideal > rd_min) ? cap_val : '0;
    assign grant          = (AW'(need) < rem_reg) ? AW'(need) : rem_reg;
    assign weff           = spread_reg ? ((wsum_reg == '0) ? VAL_W'(1) : rd_weight) : cap_val;
    assign member         = spread_reg || active_reg[idx_reg];
    assign room           = AW'(rd_ideal) - share_rd;
    assign quo_q          = div_quo[AW-1:0];
    assign q_final        = (!spread_reg && (quo_q > room)) ? room : quo_q;
    assign divisor        = spread_reg ? ((wsum_reg == '0) ? SUM_W'(cnt_reg) : wsum_reg)
                                       : csum_reg;
    assign cand           = member && !chosen_reg[idx_reg];
    assign better         = !found_reg || (remst_rd > best_r_reg) ||
                            ((remst_rd == best_r_reg) && (weff > best_w_reg));
    assign avail_c        = CMP_W'(avail_reg);
    assign min_c          = CMP_W'(min_sum_reg);
    assign ideal_c        = CMP_W'(ideal_sum_reg);

    assign slot_wd = {s_data.slot_min[VAL_W-1:0], s_data.slot_ideal[VAL_W-1:0],
                      s_data.slot_weight[VAL_W-1:0]};

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        m_valid_next   = m_valid_reg;
        avail_next     = avail_reg;
        prio_en_next   = prio_en_reg;
        prio_slot_next = prio_slot_reg;
        idx_next       = idx_reg;
        mode_next      = mode_reg;
        spread_next    = spread_reg;
        min_sum_next   = min_sum_reg;
        ideal_sum_next = ideal_sum_reg;
        wsum_next      = wsum_reg;
        csum_next      = csum_reg;
        rem_next       = rem_reg;
        used_next      = used_reg;
        prio_ok_next   = prio_ok_reg;
        prio_idx_next  = prio_idx_reg;
        any_next       = any_reg;
        found_next     = found_reg;
        best_r_next    = best_r_reg;
        best_w_next    = best_w_reg;
        best_idx_next  = best_idx_reg;
        active_next    = active_reg;
        chosen_next    = chosen_reg;
        prod_next      = prod_reg;
        m_data_next    = m_data_reg;
        slot_we        = 1'b0;
        share_we       = 1'b0;
        share_wd       = share_rd;
        remst_we       = 1'b0;
        div_start      = 1'b0;

        // Take configuration writes
        if (cfg_valid) begin
            case (cfg_index)
                REG_AVAIL:     avail_next     = cfg_data;
                REG_PRIO_EN:   prio_en_next   = cfg_data[0];
                REG_PRIO_SLOT: prio_slot_next = cfg_data[PRIO_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            // Store slots; drop those beyond capacity
            ST_LOAD: begin
                if (s_valid) begin
                    if (32'(cnt_reg) < MAX_SLOTS) begin
                        slot_we  = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (s_data.final_slot) begin
                        idx_next       = '0;
                        min_sum_next   = '0;
                        ideal_sum_next = '0;
                        wsum_next      = '0;
                        state_next     = ST_SUM_RD;
                    end
                end
            end
            ST_SUM_RD: state_next = ST_SUM_USE;
            // Accumulate the three sums
            ST_SUM_USE: begin
                min_sum_next   = min_sum_reg + SUM_W'(rd_min);
                ideal_sum_next = ideal_sum_reg + SUM_W'(rd_ideal);
                wsum_next      = wsum_reg + SUM_W'(rd_weight);
                if (last) begin
                    state_next = ST_DECIDE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SUM_RD;
                end
            end
            // Pick the case and the amount to hand out
            ST_DECIDE: begin
                if (avail_c <= min_c) begin
                    mode_next = MODE_MIN;
                end else if (ideal_c <= avail_c) begin
                    mode_next = MODE_FIT;
                    rem_next  = AW'(avail_c - ideal_c);
                end else begin
                    mode_next = MODE_CAP;
                    rem_next  = AW'(avail_c - min_c);
                end
                prio_ok_next  = prio_en_reg && (32'(prio_slot_reg) < 32'(cnt_reg));
                prio_idx_next = IDX_W'(prio_slot_reg);
                spread_next   = 1'b0;
                idx_next      = '0;
                state_next    = ST_INIT_RD;
            end
            ST_INIT_RD: state_next = ST_INIT_USE;
            // Seed each share with its ideal or its minimum
            ST_INIT_USE: begin
                share_we = 1'b1;
                share_wd = (mode_reg == MODE_FIT) ? AW'(rd_ideal) : AW'(rd_min);
                if (!last) begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_INIT_RD;
                end else begin
                    case (mode_reg)
                        MODE_MIN: begin
                            idx_next   = '0;
                            state_next = ST_EM_RD;
                        end
                        MODE_FIT: state_next = ST_SPREAD;
                        default: begin
                            if (prio_ok_reg) begin
                                idx_next   = prio_idx_reg;
                                state_next = ST_PRI_RD;
                            end else begin
                                state_next = ST_ROUND;
                            end
                        end
                    endcase
                end
            end
            ST_PRI_RD: state_next = ST_PRI_USE;
            // Raise the priority slot toward its ideal
            ST_PRI_USE: begin
                share_we   = 1'b1;
                share_wd   = AW'(rd_min) + grant;
                rem_next   = rem_reg - grant;
                state_next = ST_ROUND;
            end
            // Open one capped round
            ST_ROUND: begin
                if (rem_reg == '0) begin
                    state_next = ST_SPREAD;
                end else begin
                    idx_next   = '0;
                    any_next   = 1'b0;
                    csum_next  = '0;
                    state_next = ST_ACT_RD;
                end
            end
            ST_ACT_RD: state_next = ST_ACT_USE;
            // Mark slots other than the priority slot still below their ideal
            ST_ACT_USE: begin
                active_next[idx_reg] = !is_prio && share_lt_ideal;
                if (!is_prio && share_lt_ideal) begin
                    any_next  = 1'b1;
                    csum_next = csum_reg + SUM_W'(cap_val);
                end
                if (last) begin
                    state_next = ST_ACT_END;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_ACT_RD;
                end
            end
            ST_ACT_END: begin
                if (!any_reg) begin
                    state_next = ST_SPREAD;
                end else begin
                    idx_next   = '0;
                    used_next  = '0;
                    state_next = ST_DIV_RD;
                end
            end
            ST_DIV_RD: state_next = ST_DIV_MUL;
            // Form amount times weight, or skip a non-member
            ST_DIV_MUL: begin
                if (member) begin
                    prod_next  = PROD_W'(rem_reg) * PROD_W'(weff);
                    state_next = ST_DIV_START;
                end else if (last) begin
                    state_next = ST_TIE_PREP;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_DIV_RD;
                end
            end
            ST_DIV_START: begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            // Add the floor share and keep the remainder
            ST_DIV_WAIT: begin
                if (div_done) begin
                    share_we  = 1'b1;
                    share_wd  = share_rd + q_final;
                    remst_we  = 1'b1;
                    used_next = used_reg + q_final;
                    if (last) begin
                        state_next = ST_TIE_PREP;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_DIV_RD;
                    end
                end
            end
            // Start handing out leftover units
            ST_TIE_PREP: begin
                if (used_reg == rem_reg) begin
                    state_next = ST_ROUND_END;
                end else begin
                    chosen_next = '0;
                    found_next  = 1'b0;
                    idx_next    = '0;
                    state_next  = ST_TIE_RD;
                end
            end
            ST_TIE_RD: state_next = ST_TIE_USE;
            // Track the best unchosen member
            ST_TIE_USE: begin
                if (cand && better) begin
                    found_next    = 1'b1;
                    best_r_next   = remst_rd;
                    best_w_next   = weff;
                    best_idx_next = idx_reg;
                end
                if (last) begin
                    state_next = ST_TIE_PICK;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_TIE_RD;
                end
            end
            ST_TIE_PICK: begin
                if (!found_reg) begin
                    state_next = ST_ROUND_END;
                end else begin
                    chosen_next[best_idx_reg] = 1'b1;
                    idx_next   = best_idx_reg;
                    state_next = ST_INC_RD;
                end
            end
            ST_INC_RD: state_next = ST_INC_USE;
            // Give one unit, capped rounds only below the ideal
            ST_INC_USE: begin
                if (spread_reg || share_lt_ideal) begin
                    share_we  = 1'b1;
                    share_wd  = share_rd + 1'b1;
                    used_next = used_reg + 1'b1;
                end
                if ((spread_reg || share_lt_ideal) && (used_reg + 1'b1 == rem_reg)) begin
                    state_next = ST_ROUND_END;
                end else begin
                    found_next = 1'b0;
                    idx_next   = '0;
                    state_next = ST_TIE_RD;
                end
            end
            // Close the round and take out what was used
            ST_ROUND_END: begin
                if (spread_reg) begin
                    idx_next   = '0;
                    state_next = ST_EM_RD;
                end else if (used_reg == '0) begin
                    state_next = ST_SPREAD;
                end else begin
                    rem_next   = rem_reg - used_reg;
                    state_next = ST_ROUND;
                end
            end
            // Split any rest by weight
            ST_SPREAD: begin
                idx_next = '0;
                if (rem_reg == '0) begin
                    state_next = ST_EM_RD;
                end else begin
                    spread_next = 1'b1;
                    used_next   = '0;
                    state_next  = ST_DIV_RD;
                end
            end
            ST_EM_RD: state_next = ST_EM_LD;
            ST_EM_LD: begin
                m_data_next.slot_share  = share_rd;
                m_data_next.final_share = last;
                m_valid_next            = 1'b1;
                state_next              = ST_EM_WAIT;
            end
            // Hold the item until taken
            ST_EM_WAIT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (m_data_reg.final_share) begin
                        cnt_next   = '0;
                        state_next = ST_LOAD;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_EM_RD;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            m_valid_reg   <= 1'b0;
            avail_reg     <= '0;
            prio_en_reg   <= 1'b0;
            prio_slot_reg <= '0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            m_valid_reg   <= m_valid_next;
            avail_reg     <= avail_next;
            prio_en_reg   <= prio_en_next;
            prio_slot_reg <= prio_slot_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        mode_reg      <= mode_next;
        spread_reg    <= spread_next;
        min_sum_reg   <= min_sum_next;
        ideal_sum_reg <= ideal_sum_next;
        wsum_reg      <= wsum_next;
        csum_reg      <= csum_next;
        rem_reg       <= rem_next;
        used_reg      <= used_next;
        prio_ok_reg   <= prio_ok_next;
        prio_idx_reg  <= prio_idx_next;
        any_reg       <= any_next;
        found_reg     <= found_next;
        best_r_reg    <= best_r_next;
        best_w_reg    <= best_w_next;
        best_idx_reg  <= best_idx_next;
        active_reg    <= active_next;
        chosen_reg    <= chosen_next;
        prod_reg      <= prod_next;
        m_data_reg    <= m_data_next;
    end

    cwa_ram #(.WIDTH(3 * VAL_W), .DEPTH(MAX_SLOTS)) u_slot_ram (
        .aclk  (aclk),
        .we    (slot_we),
        .waddr (cnt_reg[IDX_W-1:0]),
        .wdata (slot_wd),
        .raddr (idx_reg),
        .rdata (slot_rd)
    );

    cwa_ram #(.WIDTH(AW), .DEPTH(MAX_SLOTS)) u_share_ram (
        .aclk  (aclk),
        .we    (share_we),
        .waddr (idx_reg),
        .wdata (share_wd),
        .raddr (idx_reg),
        .rdata (share_rd)
    );

    cwa_ram #(.WIDTH(SUM_W), .DEPTH(MAX_SLOTS)) u_remst_ram (
        .aclk  (aclk),
        .we    (remst_we),
        .waddr (idx_reg),
        .wdata (div_rem),
        .raddr (idx_reg),
        .rdata (remst_rd)
    );

    cwa_div #(.DVD_W(PROD_W), .DVS_W(SUM_W)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (prod_reg),
        .divisor   (divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign s_ready   = (state_reg == ST_LOAD);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

endmodule

// ===== src/cwa_checker.sv =====
module cwa_checker import cwa_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input slot_in_t   s_data,
    input logic       m_valid,
    input logic       m_ready,
    input share_out_t m_data
);

    // Leave reset ready to load with nothing pending
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid)
        else $error("not idle after reset");

    // Never load while a share is pending
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("loading while a share is pending");

    // Stop loading once the final slot is taken
    a_final_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.final_slot |=> !s_ready)
        else $error("still loading after final slot");

    // Return to loading after the last share is taken
    a_back_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.final_share |=> s_ready && !m_valid)
        else $error("not back to loading after last share");

    // Hold a stalled share
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled share changed");

endmodule

bind capped_weighted_apportioner_core cwa_checker u_cwa_checker (.*);

// ===== dv/capped_weighted_apportioner_core_checker.sv =====
module capped_weighted_apportioner_core_checker import cwa_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  slot_in_t             s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  share_out_t           m_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [AVAIL_W-1:0]   cfg_data,
    output int                   mismatches,
    output int                   shares_pending
);

    localparam int SLOTS = DEF_MAX_SLOTS;

    // Shadow of the slot set and of the split in progress
    longint unsigned mins [SLOTS];
    longint unsigned ideals [SLOTS];
    longint unsigned wts [SLOTS];
    longint unsigned shares [SLOTS];
    longint unsigned rmds [SLOTS];
    int unsigned     rk [SLOTS];
    int              loaded;

    // Shadow of the registers
    longint unsigned avail_units;
    bit              prio_on;
    int unsigned     prio_idx;

    share_out_t share_q[$];

    task automatic report_miss(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Rank members by larger remainder, then larger weight, then lower index
    function automatic void rank_members(input bit mem[SLOTS],
                                         input longint unsigned w[SLOTS], input int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = 0;
            if (mem[i]) begin
                for (int j = 0; j < n; j++) begin
                    if (j != i && mem[j] && (rmds[j] > rmds[i] || (rmds[j] == rmds[i] &&
                        (w[j] > w[i] || (w[j] == w[i] && j < i)))))
                        r++;
                end
            end
            rk[i] = r;
        end
    endfunction

    // Floor split by weight, then hand out the rest by largest remainder
    function automatic void spread_units(input longint unsigned amount, input int n);
        longint unsigned eff[SLOTS];
        bit              all[SLOTS];
        longint unsigned total, given, p;
        total = 0;
        given = 0;
        if (amount == 0 || n == 0) return;
        for (int i = 0; i < SLOTS; i++) begin
            eff[i] = (i < n) ? wts[i] : 0;
            all[i] = (i < n);
            total += eff[i];
        end
        if (total == 0) begin
            for (int i = 0; i < n; i++) eff[i] = 1;
            total = n;
        end
        for (int i = 0; i < n; i++) begin
            p = amount * eff[i];
            shares[i] += p / total;
            rmds[i] = p % total;
            given += p / total;
        end
        rank_members(all, eff, n);
        for (int i = 0; i < n; i++)
            if (rk[i] < amount - given) shares[i] += 1;
    endfunction

    function automatic void split_total(input int n);
        longint unsigned min_sum, ideal_sum, rest, need, grant, total, used, left, pr, q;
        longint unsigned cap[SLOTS], got[SLOTS];
        bit              act[SLOTS];
        int              pi, cnt;
        bit              found;
        min_sum = 0;
        ideal_sum = 0;
        for (int i = 0; i < n; i++) begin
            min_sum += mins[i];
            ideal_sum += ideals[i];
        end
        if (avail_units <= min_sum) begin
            for (int i = 0; i < n; i++) shares[i] = mins[i];
            return;
        end
        if (ideal_sum <= avail_units) begin
            for (int i = 0; i < n; i++) shares[i] = ideals[i];
            spread_units(avail_units - ideal_sum, n);
            return;
        end
        for (int i = 0; i < n; i++) shares[i] = mins[i];
        rest = avail_units - min_sum;
        pi = (prio_on && prio_idx < n) ? int'(prio_idx) : n;
        // Raise the priority slot toward its ideal first
        if (pi < n) begin
            need = (ideals[pi] > mins[pi]) ? ideals[pi] - mins[pi] : 0;
            grant = (need < rest) ? need : rest;
            shares[pi] += grant;
            rest -= grant;
        end
        // Capped rounds weighted by remaining need
        if (rest > 0) begin
            for (int i = 0; i < SLOTS; i++) begin
                cap[i] = (i < n && i != pi && ideals[i] > shares[i]) ?
                         ideals[i] - shares[i] : 0;
                got[i] = 0;
            end
            while (rest > 0) begin
                total = 0;
                used = 0;
                cnt = 0;
                for (int i = 0; i < SLOTS; i++) begin
                    act[i] = (i < n) && (got[i] < cap[i]);
                    if (act[i]) begin
                        cnt++;
                        total += cap[i];
                    end
                end
                if (cnt == 0) break;
                for (int i = 0; i < n; i++) begin
                    if (act[i]) begin
                        pr = rest * cap[i];
                        q = pr / total;
                        if (q > cap[i] - got[i]) q = cap[i] - got[i];
                        got[i] += q;
                        used += q;
                        rmds[i] = pr % total;
                    end
                end
                left = rest - used;
                if (left > 0) begin
                    rank_members(act, cap, n);
                    for (int r = 0; r < n && left > 0; r++) begin
                        found = 0;
                        for (int i = 0; i < n && !found; i++) begin
                            if (act[i] && rk[i] == r) begin
                                found = 1;
                                if (got[i] < cap[i]) begin
                                    got[i]++;
                                    used++;
                                    left--;
                                end
                            end
                        end
                    end
                end
                if (used == 0) break;
                rest -= used;
            end
            for (int i = 0; i < n; i++) shares[i] += got[i];
        end
        if (rest > 0) spread_units(rest, n);
    endfunction

    always @(posedge aclk) begin
        share_out_t exp_share;
        if (!aresetn) begin
            loaded = 0;
            avail_units = 0;
            prio_on = 0;
            prio_idx = 0;
            mismatches = 0;
            share_q.delete();
        end else begin
            // Track register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_AVAIL:     avail_units = 64'(cfg_data);
                    REG_PRIO_EN:   prio_on = cfg_data[0];
                    REG_PRIO_SLOT: prio_idx = 32'(cfg_data[PRIO_W-1:0]);
                    default: ;
                endcase
            end
            // Load a slot; on the final one compute and queue the shares
            if (s_valid && s_ready) begin
                if (loaded < SLOTS) begin
                    mins[loaded] = 64'(s_data.slot_min);
                    ideals[loaded] = 64'(s_data.slot_ideal);
                    wts[loaded] = 64'(s_data.slot_weight);
                    loaded = loaded + 1;
                end
                if (s_data.final_slot) begin
                    split_total(loaded);
                    for (int k = 0; k < loaded; k++) begin
                        exp_share.slot_share = shares[k][AVAIL_W-1:0];
                        exp_share.final_share = (k + 1 == loaded);
                        share_q = {share_q, exp_share};
                    end
                    loaded = 0;
                end
            end
            // Compare each accepted share with the oldest expectation
            if (m_valid && m_ready) begin
                if (share_q.size() == 0) begin
                    report_miss($sformatf("unexpected share %0d", m_data.slot_share));
                end else begin
                    exp_share = share_q.pop_front();
                    if (m_data.slot_share !== exp_share.slot_share)
                        report_miss($sformatf("slot_share %0d, want %0d",
                                              m_data.slot_share, exp_share.slot_share));
                    if (m_data.final_share !== exp_share.final_share)
                        report_miss($sformatf("final_share %0b, want %0b",
                                              m_data.final_share, exp_share.final_share));
                end
            end
        end
        shares_pending = share_q.size();
    end

endmodule

// ===== dv/capped_weighted_apportioner_core_tb.sv =====
module capped_weighted_apportioner_core_tb;
    import cwa_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    slot_in_t             s_data;
    logic                 m_valid;
    logic                 m_ready;
    share_out_t           m_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [AVAIL_W-1:0]   cfg_data;
    int                   mismatches;
    int                   shares_pending;

    int  slots_sent;
    int  s_idle_pct;
    int  m_stall_pct;
    int  hold_cycles;
    int  cycle_count;
    bit  hold_done;
    int  n_sets;

    capped_weighted_apportioner_core dut (.*);

    capped_weighted_apportioner_core_checker checker_i (.*);

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Drive the receiver: random stalls, or a long hold-off when asked
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready <= 0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= m_stall_pct);
        end
    end

    function automatic logic [IN_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2, 3: return IN_W'($urandom);
            default: return IN_W'($urandom_range(300));
        endcase
    endfunction

    task automatic send_slot(input logic [IN_W-1:0] mn, input logic [IN_W-1:0] ideal,
                             input logic [IN_W-1:0] w, input logic last);
        @(negedge aclk);
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_valid <= 1;
        s_data <= '{slot_min: mn, slot_ideal: ideal, slot_weight: w, final_slot: last};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        slots_sent++;
    endtask

    // Wait for every share to drain, then let the block settle
    task automatic drain();
        @(negedge aclk);
        s_valid <= 0;
        while (shares_pending != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [AVAIL_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    task automatic set_regs(input logic [AVAIL_W-1:0] avail, input logic en,
                            input logic [PRIO_W-1:0] slot);
        write_reg(REG_AVAIL, avail);
        write_reg(REG_PRIO_EN, AVAIL_W'(en));
        write_reg(REG_PRIO_SLOT, AVAIL_W'(slot));
    endtask

    // One set of random slots; sizes stay small apart from rare large sets that can overflow
    task automatic send_random_set();
        int n;
        n = ($urandom_range(19) == 0) ? $urandom_range(14, 19) : $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            send_slot(pick_value(), pick_value(), pick_value(), i == n - 1);
    endtask

    task automatic random_regs();
        logic [AVAIL_W-1:0] avail;
        case ($urandom_range(5))
            0: avail = '0;
            1: avail = '1;
            2: avail = AVAIL_W'($urandom);
            default: avail = AVAIL_W'($urandom_range(1500));
        endcase
        set_regs(avail, 1'($urandom_range(1)), PRIO_W'($urandom));
    endtask

    initial begin
        aresetn = 0;
        s_valid = 0;
        s_data = '0;
        m_ready = 0;
        cfg_valid = 0;
        cfg_index = REG_AVAIL;
        cfg_data = '0;
        slots_sent = 0;
        s_idle_pct = 0;
        m_stall_pct = 0;
        hold_cycles = 0;
        cycle_count = 0;
        hold_done = 0;
        n_sets = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // Total at or below the minimums, single slot, extremes
        set_regs(AVAIL_W'(0), 1'b0, PRIO_W'(0));
        send_slot(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        drain();
        // All ideals fit, all weights zero, one ideal below its minimum
        set_regs(20'hFFFFF, 1'b0, PRIO_W'(0));
        send_slot(IN_W'(10), IN_W'(20), IN_W'(0), 1'b0);
        send_slot(IN_W'(50), IN_W'(5), IN_W'(0), 1'b0);
        send_slot(IN_W'(0), IN_W'(0), IN_W'(0), 1'b1);
        drain();
        // Capped rounds with a priority slot in range
        set_regs(AVAIL_W'(300), 1'b1, PRIO_W'(1));
        send_slot(IN_W'(10), IN_W'(200), IN_W'(3), 1'b0);
        send_slot(IN_W'(20), IN_W'(150), IN_W'(1), 1'b0);
        send_slot(IN_W'(5), IN_W'(100), IN_W'(7), 1'b0);
        send_slot(IN_W'(40), IN_W'(30), IN_W'(2), 1'b1);
        drain();
        // Priority slot out of range, all ideals fit and the rest is split by weight
        write_reg(REG_PRIO_SLOT, AVAIL_W'(15));
        send_slot(IN_W'(0), IN_W'(2), IN_W'(5), 1'b0);
        send_slot(IN_W'(0), IN_W'(3), IN_W'(5), 1'b1);
        drain();
        // Overflow set: eighteen slots, the last two dropped
        set_regs(AVAIL_W'(777), 1'b1, PRIO_W'(0));
        for (int i = 0; i < 18; i++)
            send_slot(pick_value(), pick_value(), pick_value(), i == 17);
        drain();

        // Random sets through the idling phases, the registers changed before each group of sets
        while (slots_sent < 470) begin
            case ((slots_sent / 80) % 4)
                0: begin s_idle_pct = 0;  m_stall_pct = 0;  end
                1: begin s_idle_pct = 63; m_stall_pct = 0;  end
                2: begin s_idle_pct = 0;  m_stall_pct = 63; end
                default: begin s_idle_pct = 38; m_stall_pct = 38; end
            endcase
            // Once, hold off the receiver while several sets keep arriving
            if (!hold_done && slots_sent >= 200) begin
                hold_done = 1;
                s_idle_pct = 0;
                hold_cycles = 3000;
                n_sets = 3;
            end else begin
                n_sets = $urandom_range(1, 3);
            end
            random_regs();
            repeat (n_sets) send_random_set();
            drain();
        end

        s_idle_pct = 0;
        m_stall_pct = 0;
        drain();
        repeat (200) @(posedge aclk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/cwa_pkg.sv
src/cwa_ram.sv
src/cwa_div.sv
src/capped_weighted_apportioner_core.sv
src/cwa_checker.sv
dv/capped_weighted_apportioner_core_checker.sv
dv/capped_weighted_apportioner_core_tb.sv
